// ===== rtl/frds_pkg.sv =====
// shared constants and codes of the fractional rate deadline scheduler
`timescale 1ns / 1ps
package frds_pkg;
   localparam int TIME_W   = 64;
   localparam int WORD_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IDLE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_HZ   = 1'd1;

   localparam logic [WORD_W-1:0] TPS_RESET  = 32'd1000000;
   localparam logic [WORD_W-1:0] RATE_RESET = 32'd60;
   localparam logic [WORD_W-1:0] WORD_MAX   = 32'hFFFF_FFFF;
endpackage

// ===== rtl/frds_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface frds_req_if;
   logic                               valid;
   logic                               ready;
   logic [frds_pkg::CMD_W-1:0]         cmd;
   logic signed [frds_pkg::TIME_W-1:0] time_ticks;
   logic [frds_pkg::WORD_W-1:0]        steps;
   modport source (output valid, cmd, time_ticks, steps, input ready);
   modport sink (input valid, cmd, time_ticks, steps, output ready);
endinterface

interface frds_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [frds_pkg::WORD_W-1:0]        due_count;
   logic [frds_pkg::STATUS_W-1:0]      status;
   logic signed [frds_pkg::TIME_W-1:0] deadline_ticks;
   modport source (output valid, due_count, status, deadline_ticks, input ready);
   modport sink (input valid, due_count, status, deadline_ticks, output ready);
endinterface

// ===== rtl/frds_div.sv =====
// shared radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module frds_div #(
   parameter int NUM_W = frds_pkg::TIME_W,
   parameter int DEN_W = frds_pkg::WORD_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider busy at done");
endmodule

// ===== rtl/fractional_rate_deadline_scheduler.sv =====
// top level of the fractional rate deadline scheduler
`timescale 1ns / 1ps
// usage
//   requests arrive on req_chan (valid/ready); each carries cmd, time_ticks
//   and steps. one response per request leaves on rsp_chan, in order.
//   csr_wr_en/csr_index/csr_wdata write the tick rate (0) and rate_hz (1);
//   the values are latched into the schedule only by a good restart.
// work and throughput
//   one request at a time; ready is low while a request is in work.
//   multiplications and divisions run through one 64-by-32 divider and
//   a 32x32 multiplier with a registered product.
//   restart and advance: one division.
//   query: four divisions plus one per correction step, usually zero to
//   two steps; early queries need no division and saturated ones two.
//   not-started requests and unused codes need no arithmetic.
// reset
//   synchronous, active high; schedule cleared and not started, registers
//   return to 1000000 ticks per second and 60 per second.
// stall
//   the response sits in an output register until taken; a new request can
//   be accepted meanwhile, but its result waits for the register to free.
module fractional_rate_deadline_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   frds_req_if.sink                            req_chan,
   frds_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [frds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [frds_pkg::WORD_W-1:0]         csr_wdata
);
   localparam int TW = frds_pkg::TIME_W;
   localparam int WW = frds_pkg::WORD_W;

   typedef enum logic [4:0] {
      ST_IDLE, ST_STEP_MUL, ST_STEP_DIV, ST_STEP_WAIT,
      ST_Q_LIM_WAIT, ST_Q_SEC_WAIT, ST_Q_MUL1, ST_Q_MUL2, ST_Q_FRAC_MUL, ST_Q_FRAC_GO,
      ST_Q_FRAC_WAIT, ST_Q_MUL3, ST_Q_PRB_GO, ST_Q_PRB_WAIT, ST_Q_CHK, ST_Q_STEP_WAIT,
      ST_FIN
   } state_type;

   state_type state_ff;

   // configuration and latched schedule settings
   logic [WW-1:0] cfg_tps_ff, cfg_rate_ff, lat_tps_ff, lat_rate_ff;
   logic [TW-1:0] next_dl_ff;
   logic [WW-1:0] phase_ff;
   logic          started_ff;

   // work registers
   logic [TW-1:0] late_ff, delta_ff;
   logic [WW-1:0] limit_ff, partial_ff, acc_ff, est_ff, probe_ph_ff;
   logic [WW-1:0] due_ff;
   logic [frds_pkg::STATUS_W-1:0] status_ff;

   // shared multiplier
   logic [WW-1:0] mul_a_ff, mul_b_ff;
   logic [TW-1:0] mul_ff, mul_in;

   // shared divider
   logic          div_go_ff, div_busy, div_done;
   logic [TW-1:0] div_num_ff, div_quo;
   logic [WW-1:0] div_den_ff, div_rem;

   // output register
   logic          rsp_valid_ff;
   logic [WW-1:0] rsp_due_ff;
   logic [frds_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [TW-1:0] rsp_dl_ff;

   logic          out_free;
   logic          accept;
   logic [TW:0]   delta_sum;
   logic          cfg_bad;

   assign mul_in    = TW'(mul_a_ff) * TW'(mul_b_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_chan.ready;
   assign delta_sum = {1'b0, delta_ff} + {1'b0, div_quo};
   assign cfg_bad   = (cfg_tps_ff == '0) || (cfg_rate_ff == '0) || (cfg_rate_ff > cfg_tps_ff);

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.due_count      = rsp_due_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.deadline_ticks = $signed(rsp_dl_ff);

   frds_div #(.NUM_W(TW), .DEN_W(WW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_tps_ff  <= frds_pkg::TPS_RESET;
         cfg_rate_ff <= frds_pkg::RATE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            frds_pkg::CSR_TICK_RATE: cfg_tps_ff  <= csr_wdata;
            frds_pkg::CSR_RATE_HZ:   cfg_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) mul_ff <= mul_in;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         next_dl_ff   <= '0;
         phase_ff     <= '0;
         lat_tps_ff   <= '0;
         lat_rate_ff  <= '0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         // the finishing state reloads the register itself
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_FIN) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  due_ff    <= '0;
                  status_ff <= frds_pkg::STATUS_OK;
                  state_ff  <= ST_FIN;
                  unique case (req_chan.cmd)
                     frds_pkg::CMD_RESTART: begin
                        if (cfg_bad) begin
                           status_ff <= frds_pkg::STATUS_RANGE;
                        end else begin
                           lat_tps_ff  <= cfg_tps_ff;
                           lat_rate_ff <= cfg_rate_ff;
                           next_dl_ff  <= req_chan.time_ticks;
                           phase_ff    <= '0;
                           started_ff  <= 1'b1;
                           mul_a_ff    <= WW'(1);
                           mul_b_ff    <= cfg_tps_ff;
                           state_ff    <= ST_STEP_MUL;
                        end
                     end
                     frds_pkg::CMD_ADVANCE: begin
                        if (!started_ff) begin
                           status_ff <= frds_pkg::STATUS_IDLE;
                        end else begin
                           mul_a_ff <= req_chan.steps;
                           mul_b_ff <= lat_tps_ff;
                           state_ff <= ST_STEP_MUL;
                        end
                     end
                     frds_pkg::CMD_QUERY: begin
                        if (!started_ff) begin
                           status_ff <= frds_pkg::STATUS_IDLE;
                        end else if ($signed(req_chan.time_ticks) >= $signed(next_dl_ff)) begin
                           late_ff    <= req_chan.time_ticks - next_dl_ff;
                           div_num_ff <= TW'(frds_pkg::WORD_MAX);
                           div_den_ff <= lat_rate_ff;
                           div_go_ff  <= 1'b1;
                           state_ff   <= ST_Q_LIM_WAIT;
                        end
                     end
                     // unused code: answer ok, schedule unchanged
                     default: ;
                  endcase
               end
            end
            // period step on the live schedule: phase + n * tps over rate
            ST_STEP_MUL: state_ff <= ST_STEP_DIV;
            ST_STEP_DIV: begin
               div_num_ff <= mul_ff + TW'(phase_ff);
               div_den_ff <= lat_rate_ff;
               div_go_ff  <= 1'b1;
               state_ff   <= ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
               if (div_done) begin
                  next_dl_ff <= next_dl_ff + div_quo;
                  phase_ff   <= div_rem;
                  state_ff   <= ST_FIN;
               end
            end
            // saturation limit: max count over rate
            ST_Q_LIM_WAIT: begin
               if (div_done) begin
                  limit_ff   <= div_quo[WW-1:0];
                  div_num_ff <= late_ff;
                  div_den_ff <= lat_tps_ff;
                  div_go_ff  <= 1'b1;
                  state_ff   <= ST_Q_SEC_WAIT;
               end
            end
            // whole seconds and partial ticks of the late time
            ST_Q_SEC_WAIT: begin
               if (div_done) begin
                  if (div_quo >= TW'(limit_ff)) begin
                     due_ff   <= frds_pkg::WORD_MAX;
                     state_ff <= ST_FIN;
                  end else begin
                     partial_ff <= div_rem;
                     mul_a_ff   <= div_quo[WW-1:0];
                     mul_b_ff   <= lat_rate_ff;
                     state_ff   <= ST_Q_MUL1;
                  end
               end
            end
            ST_Q_MUL1: state_ff <= ST_Q_MUL2;
            ST_Q_MUL2: begin
               acc_ff   <= mul_ff[WW-1:0];
               mul_a_ff <= partial_ff;
               state_ff <= ST_Q_FRAC_MUL;
            end
            // wait for partial ticks times rate
            ST_Q_FRAC_MUL: state_ff <= ST_Q_FRAC_GO;
            ST_Q_FRAC_GO: begin
               div_num_ff <= mul_ff;
               div_den_ff <= lat_tps_ff;
               div_go_ff  <= 1'b1;
               state_ff   <= ST_Q_FRAC_WAIT;
            end
            // first estimate, then probe that many periods ahead
            ST_Q_FRAC_WAIT: begin
               if (div_done) begin
                  est_ff   <= acc_ff + div_quo[WW-1:0] + WW'(1);
                  mul_a_ff <= acc_ff + div_quo[WW-1:0] + WW'(1);
                  mul_b_ff <= lat_tps_ff;
                  state_ff <= ST_Q_MUL3;
               end
            end
            ST_Q_MUL3: state_ff <= ST_Q_PRB_GO;
            ST_Q_PRB_GO: begin
               div_num_ff <= mul_ff + TW'(phase_ff);
               div_den_ff <= lat_rate_ff;
               div_go_ff  <= 1'b1;
               state_ff   <= ST_Q_PRB_WAIT;
            end
            ST_Q_PRB_WAIT: begin
               if (div_done) begin
                  delta_ff    <= div_quo;
                  probe_ph_ff <= div_rem;
                  state_ff    <= ST_Q_CHK;
               end
            end
            // correct upward while one more deadline is already due
            ST_Q_CHK: begin
               if (est_ff != frds_pkg::WORD_MAX && delta_ff <= late_ff) begin
                  est_ff     <= est_ff + WW'(1);
                  div_num_ff <= TW'(probe_ph_ff) + TW'(lat_tps_ff);
                  div_den_ff <= lat_rate_ff;
                  div_go_ff  <= 1'b1;
                  state_ff   <= ST_Q_STEP_WAIT;
               end else begin
                  due_ff   <= est_ff;
                  state_ff <= ST_FIN;
               end
            end
            ST_Q_STEP_WAIT: begin
               if (div_done) begin
                  delta_ff    <= delta_sum[TW] ? {TW{1'b1}} : delta_sum[TW-1:0];
                  probe_ph_ff <= div_rem;
                  state_ff    <= ST_Q_CHK;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_due_ff    <= due_ff;
                  rsp_status_ff <= status_ff;
                  rsp_dl_ff     <= next_dl_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_started_sticks: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff) else $error("schedule lost its started flag");
   a_div_free_at_go: assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> !div_busy) else $error("divider issued while busy");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_dl_ff))
      else $error("response dropped under stall");
   a_range_only_restart: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && status_ff == frds_pkg::STATUS_RANGE |-> due_ff == '0)
      else $error("range error carries a count");
endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the fractional rate deadline scheduler
`timescale 1ns / 1ps
module tb_top;
   localparam int CMD_W     = frds_pkg::CMD_W;
   localparam int WORD_W    = frds_pkg::WORD_W;
   localparam int TIME_W    = frds_pkg::TIME_W;
   localparam int STATUS_W  = frds_pkg::STATUS_W;
   localparam int CSR_IDX_W = frds_pkg::CSR_IDX_W;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // longest quiet stretch: a slow query plus the long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 700;
   localparam int RANDOM_ITEMS   = 1800;

   typedef struct {
      logic [WORD_W-1:0]   due_count;
      logic [STATUS_W-1:0] status;
      logic [TIME_W-1:0]   deadline_ticks;
   } sched_rsp_type;

   typedef enum {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [CMD_W-1:0]    cmd;
      logic [TIME_W-1:0]   time_ticks;
      logic [WORD_W-1:0]   steps;
      bit                  typed;
      sched_rsp_type       rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   frds_req_if req_chan ();
   frds_rsp_if rsp_chan ();

   fractional_rate_deadline_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow of the schedule
   logic [WORD_W-1:0] sh_tps, sh_rate, sh_lat_tps, sh_lat_rate, sh_phase;
   logic [TIME_W-1:0] sh_deadline;
   bit                sh_started;

   sched_rsp_type due_q[$];
   stim_row_type  dir_rows[$];
   sched_rsp_type no_rsp = '{default: '0};
   int fail_count = 0;
   int rsp_seen = 0;
   int n_query = 0, n_advance = 0, n_restart = 0, n_other = 0, n_phases = 0;
   bit send_burst = 0;
   int quiet_cycles = 0;

   // one multi-period step: phase + n * tick rate, divided by the rate
   function automatic void period_advance(inout logic [63:0] acc, inout logic [31:0] ph,
                                          input logic [31:0] n, input bit sat);
      logic [63:0] total, quo, sum;
      total = 64'(ph) + 64'(n) * 64'(sh_lat_tps);
      quo   = total / 64'(sh_lat_rate);
      sum   = acc + quo;
      if (sat && sum < acc)
         sum = '1;
      acc = sum;
      ph  = 32'(total % 64'(sh_lat_rate));
   endfunction

   // deadlines due at now: estimate from seconds and ticks, then correct upward
   function automatic logic [31:0] count_due(logic [63:0] now);
      logic [63:0] late, whole, partial, est, delta;
      logic [31:0] ph;
      if ($signed(now) < $signed(sh_deadline))
         return '0;
      late  = now - sh_deadline;
      whole = late / 64'(sh_lat_tps);
      if (whole >= 64'(frds_pkg::WORD_MAX / sh_lat_rate))
         return frds_pkg::WORD_MAX;
      partial = late % 64'(sh_lat_tps);
      est   = whole * 64'(sh_lat_rate) + (partial * 64'(sh_lat_rate)) / 64'(sh_lat_tps)
              + 64'd1;
      delta = '0;
      ph    = sh_phase;
      period_advance(delta, ph, est[31:0], 1'b1);
      while (est < 64'(frds_pkg::WORD_MAX) && delta <= late) begin
         est++;
         period_advance(delta, ph, 32'd1, 1'b1);
      end
      return est[31:0];
   endfunction

   // applies one accepted request to the shadow and returns its response
   function automatic sched_rsp_type schedule_step(logic [CMD_W-1:0] cmd, logic [63:0] t,
                                                   logic [31:0] steps);
      sched_rsp_type r;
      r.due_count = '0;
      r.status    = frds_pkg::STATUS_OK;
      case (cmd)
         frds_pkg::CMD_QUERY: begin
            if (!sh_started) r.status = frds_pkg::STATUS_IDLE;
            else r.due_count = count_due(t);
         end
         frds_pkg::CMD_ADVANCE: begin
            if (!sh_started) r.status = frds_pkg::STATUS_IDLE;
            else period_advance(sh_deadline, sh_phase, steps, 1'b0);
         end
         frds_pkg::CMD_RESTART: begin
            if (sh_rate == 0 || sh_tps == 0 || sh_rate > sh_tps) begin
               r.status = frds_pkg::STATUS_RANGE;
            end else begin
               sh_lat_tps  = sh_tps;
               sh_lat_rate = sh_rate;
               sh_deadline = t;
               sh_phase    = '0;
               sh_started  = 1'b1;
               period_advance(sh_deadline, sh_phase, 32'd1, 1'b0);
            end
         end
         default: ;
      endcase
      r.deadline_ticks = sh_deadline;
      return r;
   endfunction

   // offer one request after a random gap (none in burst mode); predict at acceptance
   task automatic send_req(logic [CMD_W-1:0] cmd, logic [63:0] t, logic [31:0] steps,
                           bit typed, sched_rsp_type typed_rsp);
      int gap;
      sched_rsp_type r;
      gap = send_burst ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.time_ticks <= t;
      req_chan.steps      <= steps;
      do @(posedge clock); while (!req_chan.ready);
      r = schedule_step(cmd, t, steps);
      due_q.push_back(typed ? typed_rsp : r);
      case (cmd)
         frds_pkg::CMD_QUERY:   n_query++;
         frds_pkg::CMD_ADVANCE: n_advance++;
         frds_pkg::CMD_RESTART: n_restart++;
         default:               n_other++;
      endcase
   endtask

   // settings change only with nothing in flight
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == frds_pkg::CSR_TICK_RATE) sh_tps = val;
      else sh_rate = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic stim_row_type req_row(logic [CMD_W-1:0] cmd, logic [63:0] t,
                                            logic [31:0] steps);
      stim_row_type row;
      row.kind = ROW_REQ; row.cmd = cmd; row.time_ticks = t; row.steps = steps;
      row.typed = 1'b0; row.rsp = no_rsp;
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic [CMD_W-1:0] cmd, logic [63:0] t,
                                              logic [31:0] steps, logic [31:0] due,
                                              logic [1:0] st, logic [63:0] dl);
      stim_row_type row;
      row = req_row(cmd, t, steps);
      row.typed = 1'b1;
      row.rsp.due_count      = due;
      row.rsp.status         = st;
      row.rsp.deadline_ticks = dl;
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      stim_row_type row;
      row = req_row(frds_pkg::CMD_QUERY, '0, '0);
      row.kind = ROW_CSR;
      row.cmd = CMD_W'(idx);
      row.steps = val;
      return row;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // picks a setting: extremes, the reset pair, valid random, and bad ones
   task automatic pick_setting();
      logic [31:0] tps, rate;
      case ($urandom_range(0, 9))
         0: begin tps = frds_pkg::WORD_MAX; rate = frds_pkg::WORD_MAX; end
         1: begin tps = frds_pkg::WORD_MAX; rate = 32'd1; end
         2: begin tps = 32'd1; rate = 32'd1; end
         3: begin tps = frds_pkg::TPS_RESET; rate = frds_pkg::RATE_RESET; end
         4: begin tps = $urandom; rate = $urandom; end
         5: begin tps = $urandom_range(0, 1) ? 0 : $urandom; rate = $urandom_range(0, 1); end
         6: begin tps = $urandom_range(1, 100); rate = $urandom_range(1, tps); end
         default: begin
            tps  = $urandom | 32'h1;
            rate = $urandom_range(1, $urandom_range(0, 1) ? 1000 : tps);
            if (rate > tps) rate = tps;
         end
      endcase
      write_csr(frds_pkg::CSR_TICK_RATE, tps);
      write_csr(frds_pkg::CSR_RATE_HZ, rate);
   endtask

   // query time near the current deadline, from two periods before to forty after
   function automatic logic [63:0] near_time();
      longint period, off;
      period = sh_started ? longint'(sh_lat_tps / sh_lat_rate) : 100;
      off = longint'($urandom_range(0, 42)) * period - 2 * period
            + longint'($urandom_range(0, 4)) - 2;
      return sh_deadline + 64'(off);
   endfunction

   // watchdog on the handshakes
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // response side: random wait per response (none in bursts), one long hold-off to fill the block
   initial begin : rsp_sink
      int gap;
      bit burst;
      sched_rsp_type want;
      burst = 0;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_seen % 50 == 0) burst = ($urandom_range(0, 3) == 0);
         gap = burst ? 0 : $urandom_range(0, 13);
         if (rsp_seen == 300) gap = HOLD_CYCLES;
         repeat (gap) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         rsp_seen++;
         if (due_q.size() == 0) begin
            $error("response with none expected: due_count %0h status %0d",
                   rsp_chan.due_count, rsp_chan.status);
            fail_count++;
         end else begin
            want = due_q.pop_front();
            if (rsp_chan.due_count !== want.due_count) begin
               $error("due_count expected %0h actual %0h", want.due_count, rsp_chan.due_count);
               fail_count++;
            end
            if (rsp_chan.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_chan.status);
               fail_count++;
            end
            if (rsp_chan.deadline_ticks !== want.deadline_ticks) begin
               $error("deadline_ticks expected %0h actual %0h",
                      want.deadline_ticks, rsp_chan.deadline_ticks);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int sent, pick;
      logic [63:0] t;
      req_chan.valid = 1'b0;
      req_chan.cmd = frds_pkg::CMD_QUERY;
      req_chan.time_ticks = '0;
      req_chan.steps = '0;
      sh_tps = frds_pkg::TPS_RESET; sh_rate = frds_pkg::RATE_RESET;
      sh_lat_tps = '0; sh_lat_rate = '0; sh_phase = '0;
      sh_deadline = '0; sh_started = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part: not started, unused code, reset settings, extremes, bad settings
      dir_rows.push_back(typed_row(frds_pkg::CMD_QUERY, 64'd5, 32'd0, 32'd0,
                                   frds_pkg::STATUS_IDLE, 64'd0));
      dir_rows.push_back(typed_row(frds_pkg::CMD_ADVANCE, 64'd0, frds_pkg::WORD_MAX, 32'd0,
                                   frds_pkg::STATUS_IDLE, 64'd0));
      dir_rows.push_back(typed_row(CMD_UNUSED, '1, frds_pkg::WORD_MAX, 32'd0,
                                   frds_pkg::STATUS_OK, 64'd0));
      dir_rows.push_back(typed_row(frds_pkg::CMD_RESTART, 64'd0, 32'd0, 32'd0,
                                   frds_pkg::STATUS_OK, 64'd16666));
      dir_rows.push_back(typed_row(frds_pkg::CMD_QUERY, 64'd0, 32'd0, 32'd0,
                                   frds_pkg::STATUS_OK, 64'd16666));
      dir_rows.push_back(req_row(frds_pkg::CMD_QUERY, 64'd16666, 32'd0));
      dir_rows.push_back(req_row(frds_pkg::CMD_QUERY, 64'd16665, 32'd0));
      dir_rows.push_back(typed_row(frds_pkg::CMD_QUERY, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0,
                                   frds_pkg::WORD_MAX, frds_pkg::STATUS_OK, 64'd16666));
      dir_rows.push_back(typed_row(frds_pkg::CMD_QUERY, 64'h8000_0000_0000_0000, 32'd0,
                                   32'd0, frds_pkg::STATUS_OK, 64'd16666));
      dir_rows.push_back(req_row(frds_pkg::CMD_ADVANCE, 64'd0, 32'd0));
      dir_rows.push_back(req_row(frds_pkg::CMD_ADVANCE, 64'd0, frds_pkg::WORD_MAX));
      dir_rows.push_back(req_row(frds_pkg::CMD_QUERY, 64'h0000_0001_0000_0000, 32'd0));
      dir_rows.push_back(csr_row(frds_pkg::CSR_TICK_RATE, 32'd0));
      dir_rows.push_back(req_row(frds_pkg::CMD_RESTART, 64'd1, 32'd0));
      dir_rows.push_back(csr_row(frds_pkg::CSR_TICK_RATE, 32'd100));
      dir_rows.push_back(csr_row(frds_pkg::CSR_RATE_HZ, 32'd0));
      dir_rows.push_back(req_row(frds_pkg::CMD_RESTART, 64'd1, 32'd0));
      dir_rows.push_back(csr_row(frds_pkg::CSR_RATE_HZ, 32'd101));
      dir_rows.push_back(req_row(frds_pkg::CMD_RESTART, 64'd1, 32'd0));
      dir_rows.push_back(csr_row(frds_pkg::CSR_TICK_RATE, frds_pkg::WORD_MAX));
      dir_rows.push_back(csr_row(frds_pkg::CSR_RATE_HZ, frds_pkg::WORD_MAX));
      // start time at the top of the range wraps the first deadline
      dir_rows.push_back(req_row(frds_pkg::CMD_RESTART, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0));
      dir_rows.push_back(req_row(frds_pkg::CMD_QUERY, 64'h8000_0000_0000_0000, 32'd0));
      dir_rows.push_back(req_row(frds_pkg::CMD_ADVANCE, 64'd0, frds_pkg::WORD_MAX));
      dir_rows.push_back(csr_row(frds_pkg::CSR_RATE_HZ, 32'd1));
      dir_rows.push_back(req_row(frds_pkg::CMD_RESTART, 64'h8000_0000_0000_0000, 32'd0));
      dir_rows.push_back(req_row(frds_pkg::CMD_QUERY, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(CSR_IDX_W'(dir_rows[i].cmd), dir_rows[i].steps);
         end else begin
            send_req(dir_rows[i].cmd, dir_rows[i].time_ticks, dir_rows[i].steps,
                     dir_rows[i].typed, dir_rows[i].rsp);
         end
      end

      // random part: phases of one setting, a restart, then mostly near-deadline work
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         pick_setting();
         n_phases++;
         send_burst = ($urandom_range(0, 3) == 0);
         t = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom);
         send_req(frds_pkg::CMD_RESTART, t, $urandom, 1'b0, no_rsp);
         sent++;
         repeat ($urandom_range(60, 140)) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
               send_req(frds_pkg::CMD_QUERY, near_time(), $urandom, 1'b0, no_rsp);
            else if (pick < 58)
               send_req(frds_pkg::CMD_QUERY, sh_deadline, $urandom, 1'b0, no_rsp);
            else if (pick < 68)
               send_req(frds_pkg::CMD_QUERY, rand64(), $urandom, 1'b0, no_rsp);
            else if (pick < 86)
               send_req(frds_pkg::CMD_ADVANCE, rand64(), $urandom_range(0, 3), 1'b0, no_rsp);
            else if (pick < 92)
               send_req(frds_pkg::CMD_ADVANCE, rand64(), $urandom, 1'b0, no_rsp);
            else if (pick < 97)
               send_req(frds_pkg::CMD_RESTART, rand64(), $urandom, 1'b0, no_rsp);
            else
               send_req(CMD_UNUSED, rand64(), $urandom, 1'b0, no_rsp);
            sent++;
         end
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("covered %0d queries, %0d advances, %0d restarts, %0d unused codes",
               n_query, n_advance, n_restart, n_other);
      $display("over %0d settings phases, %0d responses checked", n_phases, rsp_seen);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/frds_pkg.sv
rtl/frds_if.sv
rtl/frds_div.sv
rtl/fractional_rate_deadline_scheduler.sv
verif/tb_top.sv
